/* sv/rsa_cycle_walk_fpe_assert.svh */
// Assertion macros shared by the cycle-walk FPE modules.
`ifndef RSA_CYCLE_WALK_FPE_ASSERT_SVH
`define RSA_CYCLE_WALK_FPE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RCW_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcw assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcw assertion failed");

`endif

/* sv/rcw_pkg.sv */
// Shared constants and types for the cycle-walk FPE block.
`default_nettype none

package rcw_pkg;

  localparam int MODULUS_BITS_DEF = 32;
  localparam int VALUE_W          = 64;
  localparam int WALK_LIMIT       = 64;
  localparam int RND_W            = $clog2(WALK_LIMIT + 1);
  localparam int CFG_ADDR_W       = 2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_ROUND,
    ST_SQ,
    ST_SQ_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_NEXT,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

/* sv/rcw_modmul.sv */
// Bit-serial interleaved modular multiplier: p = a * b mod n, one bit of b per cycle.
`default_nettype none
`include "rsa_cycle_walk_fpe_assert.svh"

module rcw_modmul import rcw_pkg::*; #(
  parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [MODULUS_BITS-1:0] a,
  input  logic [MODULUS_BITS-1:0] b,
  input  logic [MODULUS_BITS-1:0] n,
  output logic                    done,
  output logic [MODULUS_BITS-1:0] p
);

  localparam int MB    = MODULUS_BITS;
  localparam int CNT_W = $clog2(MB);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MB-1:0]     a_r;
  logic [MB-1:0]     b_sh_r;
  logic [MB-1:0]     n_r;
  logic [MB-1:0]     p_r;

  logic [MB+1:0]     sum;
  logic [MB+2:0]     diff1;
  logic [MB+2:0]     diff2;
  logic [MB-1:0]     p_nxt;

  // 2p + a stays below 3n, so at most n or 2n comes off.
  always_comb begin
    sum   = {1'b0, p_r, 1'b0} + {2'b00, (b_sh_r[MB-1] ? a_r : {MB{1'b0}})};
    diff1 = {1'b0, sum} - {3'b000, n_r};
    diff2 = {1'b0, sum} - {2'b00, n_r, 1'b0};
    if (!diff2[MB+2]) begin
      p_nxt = diff2[MB-1:0];
    end else if (!diff1[MB+2]) begin
      p_nxt = diff1[MB-1:0];
    end else begin
      p_nxt = sum[MB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_sh_r <= b;
      n_r    <= n;
      p_r    <= '0;
    end else if (busy_r) begin
      p_r    <= p_nxt;
      b_sh_r <= {b_sh_r[MB-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign p    = p_r;

  `RCW_ASSERT_NEXT(a_start_busy, start, busy_r)
  `RCW_ASSERT_HOLDS(a_done_idle, done_r, !busy_r)
  `RCW_ASSERT_HOLDS(a_done_reduced, done_r, p_r < n_r)

endmodule

`default_nettype wire

/* sv/rsa_cycle_walk_fpe.sv */
// Top level of the RSA format-preserving cycle-walk encrypter.
//
//  Channel   Ports              Payload (lowest bit first)
//  --------  -----------------  -------------------------------------------
//  input     in_t*              tdata: plain_value[63:0]; tuser: op
//  result    out_t*             tdata: result_value[63:0]; tuser: key_invalid
//  config    cfg_we/addr/wdata  0 modulus, 1 public exp, 2 private exp
//
// One item is in work at a time. With t = position of the exponent's top
// bit and w = ones below it, a walk round runs t squarings and w
// multiplications on the serial multiplier; an item passes through
// acceptance, check, top-bit scan and its rounds (at most 64), then hand-off.
// Reset (rst_n low, synchronous) clears the key registers and all control.
// A finished result waits in the output register; a new transfer is taken
// while it waits, and the next result stalls only until that one is taken.
`default_nettype none
`include "rsa_cycle_walk_fpe_assert.svh"

module rsa_cycle_walk_fpe import rcw_pkg::*; #(
  parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [VALUE_W-1:0]      in_tdata,   // [63:0] plain_value
  input  logic [0:0]              in_tuser,   // [0] op
  // result channel
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [VALUE_W-1:0]      out_tdata,  // [63:0] result_value
  output logic [0:0]              out_tuser,  // [0] key_invalid
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [MODULUS_BITS-1:0] cfg_wdata
);

  localparam int MB    = MODULUS_BITS;
  localparam int CNT_W = $clog2(MB);

  // Key registers.
  logic [MB-1:0] modulus_r;
  logic [MB-1:0] pub_exp_r;
  logic [MB-1:0] priv_exp_r;

  state_t state_r, state_nxt;

  // Item working registers. The key is copied at acceptance so that the
  // whole walk sees one consistent key.
  logic [VALUE_W-1:0] val_r;
  logic [MB-1:0]      key_n_r;
  logic [MB-1:0]      key_k_r;
  logic [MB-1:0]      n_sh_r;     // modulus shifted up during the top-bit scan
  logic [MB-1:0]      k_sh_r;     // exponent, normalized so its top bit is MSB
  logic [MB-1:0]      mask_r;     // 2^r - 1, shrinks along with the scan
  logic [CNT_W-1:0]   kcnt_r;     // position of the exponent's top bit
  logic [MB-1:0]      x_r;        // base of the current round
  logic [MB-1:0]      acc_r;      // running power
  logic [MB-1:0]      e_sh_r;     // exponent bits still to apply, MSB first
  logic [CNT_W-1:0]   ebits_r;
  logic [RND_W-1:0]   rnd_r;
  logic [VALUE_W-1:0] res_r;
  logic               bad_r;

  logic               out_tvalid_r;
  logic [VALUE_W-1:0] out_tdata_r;
  logic               out_bad_r;

  logic               in_accept;
  logic               key_bad;
  logic               val_zero;
  logic               scan_done;
  logic               walk_fit;
  logic               last_round;
  logic               out_free;
  logic               mul_start;
  logic [MB-1:0]      mul_b;
  logic               mul_done;
  logic [MB-1:0]      mul_p;
  logic [VALUE_W-1:0] mask_ext;

  // ---------------------------------------------------------------------
  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= '0;
      pub_exp_r  <= '0;
      priv_exp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_PUB_EXP:  pub_exp_r  <= cfg_wdata;
        REG_PRIV_EXP: priv_exp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Status terms used by the sequencer.
  assign in_accept  = in_tvalid && in_tready;
  // The exponent must lie strictly between 1 and a nonzero modulus.
  assign key_bad    = (key_n_r == '0) || (key_k_r[MB-1:1] == '0) || (key_k_r >= key_n_r);
  assign val_zero   = (val_r == '0);
  // The scan ends once both the modulus and exponent have their top bit at MSB.
  assign scan_done  = n_sh_r[MB-1] && k_sh_r[MB-1];
  // A power fits the format when nothing sits at or above bit r.
  assign walk_fit   = ((acc_r & ~mask_r) == '0);
  assign last_round = (rnd_r == RND_W'(WALK_LIMIT - 1));
  assign out_free   = !out_tvalid_r || out_tready;
  assign mask_ext   = {{(VALUE_W - MB){1'b0}}, mask_r};

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_accept) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = (key_bad || val_zero) ? ST_FINISH : ST_SCAN;
      ST_SCAN:     if (scan_done) state_nxt = ST_ROUND;
      ST_ROUND:    state_nxt = ST_SQ;
      ST_SQ:       state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (mul_done) state_nxt = e_sh_r[MB-1] ? ST_MUL : ST_NEXT;
      ST_MUL:      state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: if (mul_done) state_nxt = ST_NEXT;
      ST_NEXT:     state_nxt = (ebits_r == CNT_W'(1)) ? ST_WALK : ST_SQ;
      ST_WALK:     state_nxt = (walk_fit || last_round) ? ST_FINISH : ST_ROUND;
      ST_FINISH:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: outputs. The multiplier squares the running power, or
  // multiplies it by the round's base when the exponent bit is set.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mul_start = (state_r == ST_SQ) || (state_r == ST_MUL);
    mul_b     = (state_r == ST_MUL) ? x_r : acc_r;
  end

  rcw_modmul #(
    .MODULUS_BITS(MODULUS_BITS)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (acc_r),
    .b     (mul_b),
    .n     (key_n_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  // ---------------------------------------------------------------------
  // Datapath registers, each loaded in the state that owns it.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          val_r   <= in_tdata;
          key_n_r <= modulus_r;
          key_k_r <= (in_tuser[0] == OP_DECRYPT) ? priv_exp_r : pub_exp_r;
        end
      end
      ST_CHECK: begin
        n_sh_r <= key_n_r;
        k_sh_r <= key_k_r;
        mask_r <= {1'b0, {(MB - 1){1'b1}}};
        kcnt_r <= CNT_W'(MB - 1);
        rnd_r  <= '0;
        res_r  <= key_bad ? val_r : '0;
        bad_r  <= key_bad;
      end
      ST_SCAN: begin
        // Each side shifts until its top bit reaches MSB; the mask follows
        // the modulus so it ends as 2^r - 1.
        if (!n_sh_r[MB-1]) begin
          n_sh_r <= {n_sh_r[MB-2:0], 1'b0};
          mask_r <= {1'b0, mask_r[MB-1:1]};
        end
        if (!k_sh_r[MB-1]) begin
          k_sh_r <= {k_sh_r[MB-2:0], 1'b0};
          kcnt_r <= kcnt_r - 1'b1;
        end
        if (scan_done) begin
          acc_r <= val_r[MB-1:0] & mask_r;
        end
      end
      ST_ROUND: begin
        // The top exponent bit is the initial power itself.
        x_r     <= acc_r;
        e_sh_r  <= {k_sh_r[MB-2:0], 1'b0};
        ebits_r <= kcnt_r;
      end
      ST_SQ_WAIT, ST_MUL_WAIT: begin
        if (mul_done) begin
          acc_r <= mul_p;
        end
      end
      ST_NEXT: begin
        e_sh_r  <= {e_sh_r[MB-2:0], 1'b0};
        ebits_r <= ebits_r - 1'b1;
      end
      ST_WALK: begin
        rnd_r <= rnd_r + 1'b1;
        if (walk_fit) begin
          res_r <= (val_r & ~mask_ext) | {{(VALUE_W - MB){1'b0}}, acc_r};
          bad_r <= 1'b0;
        end else if (last_round) begin
          // The walk did not come back; the value passes through flagged.
          res_r <= val_r;
          bad_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_FINISH) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      out_tdata_r <= res_r;
      out_bad_r   <= bad_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_bad_r;

  `RCW_ASSERT_NEXT(a_accept_check, in_tvalid && in_tready, state_r == ST_CHECK)
  `RCW_ASSERT_HOLDS(a_operands_reduced, (state_r == ST_SQ) || (state_r == ST_MUL),
                    (acc_r < key_n_r) && (x_r < key_n_r))
  `RCW_ASSERT_HOLDS(a_walk_bound, state_r == ST_WALK, rnd_r < RND_W'(WALK_LIMIT))

endmodule

`default_nettype wire
